[hdl/spt_pkg.sv]
package spt_pkg;

   // Default sizing of the table.
   localparam int MAX_SYMBOLS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   // Fixed field widths of the channels.
   localparam int KIND_W   = 3;
   localparam int SYMBOL_W = 8;
   localparam int WEIGHT_W = 17;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Learning rate after reset.
   localparam logic [WEIGHT_W-1:0] RATE_RESET = 17'd3277;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_INCREASE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT_AVG   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT_WGT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE       = 3'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SOLE   = 2'd3;

endpackage

[hdl/spt_cell.sv]
module spt_cell #(
   parameter int PW = spt_pkg::FRAC_BITS_DEF + 2
) (
   input  logic                          clock,
   input  logic                          shift,
   input  logic [spt_pkg::SYMBOL_W-1:0]  sym_in,
   input  logic [PW-1:0]                 prob_in,
   output logic [spt_pkg::SYMBOL_W-1:0]  sym_out,
   output logic [PW-1:0]                 prob_out
);

   logic [spt_pkg::SYMBOL_W-1:0] sym_ff;
   logic [PW-1:0]                prob_ff;

   // One table entry; it takes its neighbor's entry when the ring advances.
   always_ff @(posedge clock) begin
      if (shift) begin
         sym_ff  <= sym_in;
         prob_ff <= prob_in;
      end
   end

   assign sym_out  = sym_ff;
   assign prob_out = prob_ff;

endmodule

[hdl/spt_div.sv]
module spt_div #(
   parameter int XW = spt_pkg::FRAC_BITS_DEF + 2,
   parameter int DW = spt_pkg::FRAC_BITS_DEF + 7,
   parameter int QW = spt_pkg::FRAC_BITS_DEF + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [XW-1:0] x,
   input  logic [DW-1:0] d,
   output logic          done,
   output logic [QW-1:0] q
);

   // Computes (x << (QW-1)) / d one quotient bit per cycle. The top bits of
   // the dividend, x >> 1, must already be below d.
   localparam int KW = $clog2(QW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [KW-1:0] cnt_ff;
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] low_ff;
   logic [QW-1:0] q_ff;
   logic [DW-1:0] d_ff;
   logic [DW:0]   trial;
   logic          fits;

   // Trial subtraction of the divisor from the shifted remainder.
   assign trial = {rem_ff, low_ff[QW-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= DW'(x >> 1);
            low_ff  <= {x[0], {(QW-1){1'b0}}};
            d_ff    <= d;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= DW'(trial - {1'b0, d_ff});
            end else begin
               rem_ff <= DW'(trial);
            end
            q_ff   <= {q_ff[QW-2:0], fits};
            low_ff <= low_ff << 1;
            cnt_ff <= cnt_ff + KW'(1);
            if (cnt_ff == KW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

[hdl/symbol_probability_table_core.sv]
// Symbol probability table.
// An item enters on the req_ channel (kind, symbol, weights) when req_valid and
// req_ready are both high; one result item leaves on the rsp_ channel (found,
// status, best symbol, entry count) when rsp_valid and rsp_ready are high.
// The csr_ port writes the learning rate; write it only while idle.
// The entries sit in a ring of MAX_SYMBOLS cells that advances one place per
// step in front of a shared unit, so each pass visits every cell once. An
// update takes a lookup pass, an update pass and a best-symbol pass, plus one
// bit-serial division per live entry when the table is renormalized, and one
// more division for an average insert; a query or a refused update takes only
// the lookup pass and the best-symbol pass.
// One item is worked on at a time. req_ready is high only between items, but
// a new item is taken while the previous result still waits on rsp_ready; a
// result that cannot leave holds the block until the output register frees.
// Synchronous reset empties the table, drops any pending result and restores
// the learning rate to its reset value.
module symbol_probability_table_core #(
   parameter int MAX_SYMBOLS = spt_pkg::MAX_SYMBOLS_DEF,
   parameter int FRAC_BITS   = spt_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [spt_pkg::KIND_W-1:0]     req_kind,
   input  logic [spt_pkg::SYMBOL_W-1:0]   req_symbol,
   input  logic [spt_pkg::WEIGHT_W-1:0]   req_keep_weight,
   input  logic [spt_pkg::WEIGHT_W-1:0]   req_add_weight,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_found,
   output logic [spt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [spt_pkg::SYMBOL_W-1:0]   rsp_best_symbol,
   output logic [spt_pkg::COUNT_W-1:0]    rsp_entry_count,
   input  logic                           csr_write_enable,
   input  logic [spt_pkg::WEIGHT_W-1:0]   csr_write_data
);

   localparam int N   = MAX_SYMBOLS;
   localparam int F   = FRAC_BITS;
   localparam int QW  = F + 1;
   localparam int PW  = F + 2;
   localparam int CW  = $clog2(N + 1);
   localparam int IW  = $clog2(N);
   localparam int SW  = PW + $clog2(N + 1);
   localparam int FW  = spt_pkg::WEIGHT_W;
   localparam int SYW = spt_pkg::SYMBOL_W;
   localparam int EW  = (FW > PW) ? FW : PW;
   localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};
   localparam logic [EW-1:0] ONE_E = EW'(ONE_Q);

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_PLAN, S_SHARE_GO, S_SHARE_WAIT, S_MOD, S_REM,
      S_CHK, S_DIV_ISSUE, S_DIV_WAIT, S_BEST, S_OUT
   } state_type;

   // Weights above one count as one.
   function automatic logic [QW-1:0] sat_field(input logic [FW-1:0] v);
      logic [EW-1:0] ve;
      ve = EW'(v);
      if (ve > ONE_E) begin
         return ONE_Q;
      end
      return QW'(ve);
   endfunction

   state_type            state_ff;
   logic [IW-1:0]        idx_ff;
   logic [CW-1:0]        count_ff;
   logic [FW-1:0]        rate_ff;
   logic [spt_pkg::KIND_W-1:0] kind_ff;
   logic [SYW-1:0]       sym_ff;
   logic [QW-1:0]        keep_ff;
   logic [QW-1:0]        add_ff;
   logic [IW-1:0]        pos_ff;
   logic                 found_ff;
   logic [spt_pkg::STATUS_W-1:0] status_ff;
   logic                 empty_ff;
   logic                 ins_ff;
   logic [QW-1:0]        u_ff;
   logic [SW-1:0]        sum_ff;
   logic [SYW-1:0]       hold_sym_ff;
   logic [PW-1:0]        hold_prob_ff;
   logic [PW-1:0]        bp_ff;
   logic [SYW-1:0]       bs_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [spt_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [SYW-1:0]       rsp_best_ff;
   logic [CW-1:0]        rsp_count_ff;

   // Ring of cells: cell 0 is the head, the pushed entry enters at the tail.
   logic [SYW-1:0] ring_sym  [0:N];
   logic [PW-1:0]  ring_prob [0:N];
   logic           shift;
   logic [SYW-1:0] push_sym;
   logic [PW-1:0]  push_prob;

   assign ring_sym[N]  = push_sym;
   assign ring_prob[N] = push_prob;

   for (genvar g = 0; g < N; g++) begin : g_cell
      spt_cell #(.PW(PW)) u_cell (
         .clock    (clock),
         .shift    (shift),
         .sym_in   (ring_sym[g+1]),
         .prob_in  (ring_prob[g+1]),
         .sym_out  (ring_sym[g]),
         .prob_out (ring_prob[g])
      );
   end

   logic [SYW-1:0] head_sym;
   logic [PW-1:0]  head_prob;
   assign head_sym  = ring_sym[0];
   assign head_prob = ring_prob[0];

   // Shared divider for the average share and the renormalization.
   logic          div_start;
   logic [PW-1:0] div_x;
   logic [SW-1:0] div_d;
   logic          div_done;
   logic [QW-1:0] div_q;

   spt_div #(.XW(PW), .DW(SW), .QW(QW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .d     (div_d),
      .done  (div_done),
      .q     (div_q)
   );

   // Per-step arithmetic on the head entry.
   logic [QW-1:0]      rate_sat;
   logic [QW-1:0]      head_sat;
   logic [2*QW-1:0]    inc_prod;
   logic [QW-1:0]      u_calc;
   logic [PW+QW-1:0]   keep_prod;
   logic [PW-1:0]      scaled;
   logic               at_pos;
   logic               idx_valid;
   logic               idx_last;
   logic               sum_take;

   assign rate_sat  = sat_field(rate_ff);
   assign head_sat  = (head_prob > PW'(ONE_Q)) ? ONE_Q : QW'(head_prob);
   assign inc_prod  = rate_sat * (ONE_Q - head_sat);
   assign u_calc    = QW'(inc_prod >> F);
   assign keep_prod = head_prob * keep_ff;
   assign scaled    = PW'(keep_prod >> F);
   assign at_pos    = idx_ff == pos_ff;
   assign idx_valid = CW'(idx_ff) < count_ff;
   assign idx_last  = idx_ff == IW'(N - 1);

   // Entries that count toward the sum in the update passes.
   always_comb begin
      if (state_ff == S_REM) begin
         sum_take = (CW + 1)'(idx_ff) + (CW + 1)'(1) < (CW + 1)'(count_ff);
      end else begin
         sum_take = (CW + 1)'(idx_ff) < (CW + 1)'(count_ff) + (CW + 1)'(ins_ff);
      end
   end

   // Divisor selection.
   always_comb begin
      if (state_ff == S_SHARE_GO || state_ff == S_SHARE_WAIT) begin
         div_d = SW'(count_ff);
      end else if (kind_ff == spt_pkg::KIND_INCREASE) begin
         div_d = SW'(ONE_Q) + SW'(u_ff);
      end else begin
         div_d = sum_ff;
      end
   end

   // Ring control and the entry pushed at the tail.
   always_comb begin
      shift     = 1'b0;
      push_sym  = head_sym;
      push_prob = head_prob;
      div_start = 1'b0;
      div_x     = head_prob;
      unique case (state_ff)
         S_FIND, S_BEST: begin
            shift = 1'b1;
         end
         S_MOD: begin
            shift = 1'b1;
            if (kind_ff == spt_pkg::KIND_INCREASE) begin
               if (at_pos) begin
                  push_prob = PW'(head_prob + PW'(u_calc));
               end
            end else if (empty_ff) begin
               if (idx_ff == '0) begin
                  push_sym  = sym_ff;
                  push_prob = PW'(ONE_Q);
               end
            end else if (ins_ff) begin
               if (idx_ff == IW'(1)) begin
                  push_sym  = sym_ff;
                  push_prob = PW'(add_ff);
               end else if (idx_ff > IW'(1)) begin
                  push_sym  = hold_sym_ff;
                  push_prob = hold_prob_ff;
               end else begin
                  push_prob = scaled;
               end
            end else if (at_pos) begin
               push_prob = PW'(scaled + PW'(add_ff));
            end else begin
               push_prob = scaled;
            end
         end
         S_REM: begin
            shift = 1'b1;
            if (!(idx_ff < pos_ff)) begin
               push_sym  = ring_sym[1];
               push_prob = ring_prob[1];
            end
         end
         S_SHARE_GO: begin
            div_start = 1'b1;
            div_x     = PW'(1);
         end
         S_DIV_ISSUE: begin
            if (idx_valid) begin
               div_start = 1'b1;
            end else begin
               shift = 1'b1;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               shift     = 1'b1;
               push_prob = PW'(div_q);
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer, table count and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         rate_ff      <= spt_pkg::RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            rate_ff <= csr_write_data;
         end
         // The output state reloads the result register itself.
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (shift) begin
            idx_ff <= idx_last ? '0 : idx_ff + IW'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff   <= req_kind;
                  sym_ff    <= req_symbol;
                  keep_ff   <= sat_field(req_keep_weight);
                  add_ff    <= sat_field(req_add_weight);
                  found_ff  <= 1'b0;
                  status_ff <= spt_pkg::STATUS_OK;
                  empty_ff  <= 1'b0;
                  ins_ff    <= 1'b0;
                  sum_ff    <= '0;
                  bp_ff     <= '0;
                  bs_ff     <= '0;
                  state_ff  <= S_FIND;
               end
            end
            S_FIND: begin
               if (idx_valid && head_sym == sym_ff && !found_ff) begin
                  found_ff <= 1'b1;
                  pos_ff   <= idx_ff;
               end
               if (idx_last) begin
                  state_ff <= S_PLAN;
               end
            end
            S_PLAN: begin
               priority case (kind_ff)
                  spt_pkg::KIND_INCREASE: begin
                     if (found_ff) begin
                        state_ff <= S_MOD;
                     end else begin
                        status_ff <= spt_pkg::STATUS_ABSENT;
                        state_ff  <= S_BEST;
                     end
                  end
                  spt_pkg::KIND_INSERT_AVG, spt_pkg::KIND_INSERT_WGT: begin
                     if (count_ff == '0) begin
                        empty_ff <= 1'b1;
                        state_ff <= S_MOD;
                     end else if (!found_ff && count_ff >= CW'(N)) begin
                        status_ff <= spt_pkg::STATUS_FULL;
                        state_ff  <= S_BEST;
                     end else begin
                        ins_ff <= !found_ff;
                        if (kind_ff == spt_pkg::KIND_INSERT_AVG) begin
                           keep_ff  <= ONE_Q;
                           state_ff <= S_SHARE_GO;
                        end else begin
                           state_ff <= S_MOD;
                        end
                     end
                  end
                  spt_pkg::KIND_REMOVE: begin
                     if (!found_ff) begin
                        status_ff <= spt_pkg::STATUS_ABSENT;
                        state_ff  <= S_BEST;
                     end else if (count_ff <= CW'(1)) begin
                        status_ff <= spt_pkg::STATUS_SOLE;
                        state_ff  <= S_BEST;
                     end else begin
                        state_ff <= S_REM;
                     end
                  end
                  default: begin
                     status_ff <= found_ff ? spt_pkg::STATUS_OK : spt_pkg::STATUS_ABSENT;
                     state_ff  <= S_BEST;
                  end
               endcase
            end
            S_SHARE_GO: begin
               state_ff <= S_SHARE_WAIT;
            end
            S_SHARE_WAIT: begin
               if (div_done) begin
                  add_ff   <= div_q;
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               if (kind_ff == spt_pkg::KIND_INCREASE && at_pos) begin
                  u_ff <= u_calc;
               end
               if (idx_ff != '0) begin
                  hold_sym_ff  <= head_sym;
                  hold_prob_ff <= scaled;
               end
               if (sum_take) begin
                  sum_ff <= sum_ff + SW'(push_prob);
               end
               if (idx_last) begin
                  if (empty_ff) begin
                     count_ff <= CW'(1);
                     state_ff <= S_BEST;
                  end else begin
                     count_ff <= count_ff + CW'(ins_ff);
                     state_ff <= S_CHK;
                  end
               end
            end
            S_REM: begin
               if (sum_take) begin
                  sum_ff <= sum_ff + SW'(push_prob);
               end
               if (idx_last) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               // A zero sum leaves the entries as they are.
               state_ff <= (div_d == '0) ? S_BEST : S_DIV_ISSUE;
            end
            S_DIV_ISSUE: begin
               if (idx_valid) begin
                  state_ff <= S_DIV_WAIT;
               end else if (idx_last) begin
                  state_ff <= S_BEST;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  state_ff <= idx_last ? S_BEST : S_DIV_ISSUE;
               end
            end
            S_BEST: begin
               if (idx_valid && head_prob > bp_ff) begin
                  bp_ff <= head_prob;
                  bs_ff <= head_sym;
               end
               if (idx_last) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_found_ff  <= found_ff;
                  rsp_status_ff <= status_ff;
                  rsp_best_ff   <= bs_ff;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = state_ff == S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_best_symbol = rsp_best_ff;
   assign rsp_entry_count = spt_pkg::COUNT_W'(rsp_count_ff);

endmodule
